/* hdl/tpd_pkg.sv */
// ----------------------------------------------------------------------------
// Pixel palette decoder package
// Shared widths, codes, structures and the channel expansion table.
// ----------------------------------------------------------------------------
package tpd_pkg;

  localparam int FUNC_W  = 1;
  localparam int INDEX_W = 8;
  localparam int COLOR_W = 16;
  localparam int PIXEL_W = 24;
  localparam int CHAN_W  = 8;
  localparam int MODE_W  = 2;
  localparam int COUNT_W = 9;
  localparam int RGB15_W = 15;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [FUNC_W-1:0] FUNC_PALETTE = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_PIXEL   = 1'b1;

  localparam logic [MODE_W-1:0] MODE_IDX4  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_IDX8  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RGB15 = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RGB24 = 2'd3;

  localparam logic REG_PIXEL_MODE  = 1'b0;
  localparam logic REG_COLOR_COUNT = 1'b1;

  localparam logic [MODE_W-1:0]  PIXEL_MODE_RST  = MODE_IDX4;
  localparam logic [COUNT_W-1:0] COLOR_COUNT_RST = 9'd256;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_LOOKUP,
    OP_RGB15,
    OP_RGB24
  } op_kind_e;

  typedef struct packed {
    op_kind_e             kind;
    logic [INDEX_W-1:0]   addr;
    logic [PIXEL_W-1:0]   data;
    logic                 last;
  } op_t;

  typedef struct packed {
    logic [MODE_W-1:0]  pixel_mode;
    logic [COUNT_W-1:0] color_count;
  } cfg_t;

  // Expands a 5-bit channel to 8 bits as floor(c * 255 / 31).
  function automatic logic [CHAN_W-1:0] chan_expand(input logic [4:0] c);
    logic [CHAN_W-1:0] r;
    case (c)
      5'd0:  r = 8'd0;
      5'd1:  r = 8'd8;
      5'd2:  r = 8'd16;
      5'd3:  r = 8'd24;
      5'd4:  r = 8'd32;
      5'd5:  r = 8'd41;
      5'd6:  r = 8'd49;
      5'd7:  r = 8'd57;
      5'd8:  r = 8'd65;
      5'd9:  r = 8'd74;
      5'd10: r = 8'd82;
      5'd11: r = 8'd90;
      5'd12: r = 8'd98;
      5'd13: r = 8'd106;
      5'd14: r = 8'd115;
      5'd15: r = 8'd123;
      5'd16: r = 8'd131;
      5'd17: r = 8'd139;
      5'd18: r = 8'd148;
      5'd19: r = 8'd156;
      5'd20: r = 8'd164;
      5'd21: r = 8'd172;
      5'd22: r = 8'd180;
      5'd23: r = 8'd189;
      5'd24: r = 8'd197;
      5'd25: r = 8'd205;
      5'd26: r = 8'd213;
      5'd27: r = 8'd222;
      5'd28: r = 8'd230;
      5'd29: r = 8'd238;
      5'd30: r = 8'd246;
      default: r = 8'd255;
    endcase
    return r;
  endfunction

endpackage

/* hdl/tpd_if.sv */
// ----------------------------------------------------------------------------
// Pixel palette decoder stream interfaces
// Valid/ready channels for input items and decoded pixels.
// ----------------------------------------------------------------------------
interface tpd_in_if;
  import tpd_pkg::*;

  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [INDEX_W-1:0] palette_index;
  logic [COLOR_W-1:0] palette_color;
  logic [PIXEL_W-1:0] pixel_data;

  modport source (
    output valid, func, palette_index, palette_color, pixel_data,
    input  ready
  );
  modport sink (
    input  valid, func, palette_index, palette_color, pixel_data,
    output ready
  );
endinterface

interface tpd_out_if;
  import tpd_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  logic              last_of_item;

  modport source (
    output valid, red, green, blue, last_of_item,
    input  ready
  );
  modport sink (
    input  valid, red, green, blue, last_of_item,
    output ready
  );
endinterface

/* hdl/tim_pixel_palette_decoder_core.sv */
// An item passes the front hold register, operation queue, lookup stage and output register.
// Throughput: one item per cycle in the eight-bit, fifteen-bit and 24-bit modes while the
// output is ready; four-bit items yield two pixels each, retired at one pixel per cycle.
// In-range palette writes take one queue slot and produce no pixel; others are dropped.
// Reset clears all control state, sets pixel_mode to 0 and color_count to 256.
// Palette memory contents are undefined until written; no clearing pass is run.
// ----------------------------------------------------------------------------
// Pixel palette decoder top level
// Configuration registers, front end, operation queue and palette back end.
// ----------------------------------------------------------------------------
module tim_pixel_palette_decoder_core #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tpd_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [tpd_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [tpd_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  tpd_in_if.sink                           pixel_in_i,
  tpd_out_if.source                        pixel_out_o
);
  import tpd_pkg::*;

  cfg_t cfg_q;
  op_t  front_op;
  logic front_valid;
  logic front_ready;
  op_t  back_op;
  logic back_valid;
  logic back_ready;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pixel_mode  <= PIXEL_MODE_RST;
      cfg_q.color_count <= COLOR_COUNT_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_PIXEL_MODE) begin
        cfg_q.pixel_mode <= pwdata[MODE_W-1:0];
      end else begin
        cfg_q.color_count <= pwdata[COUNT_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_COLOR_COUNT) begin
      prdata = APB_DATA_W'(cfg_q.color_count);
    end else begin
      prdata = APB_DATA_W'(cfg_q.pixel_mode);
    end
  end

  tpd_front #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .in_i      (pixel_in_i),
    .op_o      (front_op),
    .op_valid_o(front_valid),
    .op_ready_i(front_ready)
  );

  tpd_op_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_op_i   (front_op),
    .wr_valid_i(front_valid),
    .wr_ready_o(front_ready),
    .rd_op_o   (back_op),
    .rd_valid_o(back_valid),
    .rd_ready_i(back_ready)
  );

  tpd_back #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .op_i      (back_op),
    .op_valid_i(back_valid),
    .op_ready_o(back_ready),
    .out_o     (pixel_out_o)
  );

endmodule

/* hdl/tpd_front.sv */
// ----------------------------------------------------------------------------
// Pixel palette decoder front end
// Holds one input item and turns it into palette and pixel operations.
// ----------------------------------------------------------------------------
module tpd_front #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tpd_pkg::cfg_t cfg_i,
  tpd_in_if.sink        in_i,
  output tpd_pkg::op_t  op_o,
  output logic          op_valid_o,
  input  logic          op_ready_i
);
  import tpd_pkg::*;

  localparam logic [COUNT_W-1:0] DepthLimit = COUNT_W'(PALETTE_DEPTH);

  logic               hold_q, hold_d;
  logic               phase_q, phase_d;
  logic [FUNC_W-1:0]  func_q;
  logic [INDEX_W-1:0] pidx_q;
  logic [COLOR_W-1:0] pcol_q;
  logic [PIXEL_W-1:0] pix_q;

  logic               accept;
  logic               is_write;
  logic               is_split;
  logic               drop;
  logic               push;
  logic               done;
  logic [INDEX_W-1:0] raw_idx;
  logic [INDEX_W-1:0] safe_idx;

  assign accept   = in_i.valid & in_i.ready;
  assign is_write = (func_q == FUNC_PALETTE);
  assign is_split = !is_write && (cfg_i.pixel_mode == MODE_IDX4) && !phase_q;
  assign drop     = is_write && ({1'b0, pidx_q} >= DepthLimit);
  assign push     = hold_q & !drop & op_ready_i;
  assign done     = hold_q & (drop | (push & !is_split));
  assign in_i.ready = !hold_q | done;
  assign op_valid_o = hold_q & !drop;

  always_comb begin
    if (cfg_i.pixel_mode == MODE_IDX4) begin
      raw_idx = phase_q ? {4'b0, pix_q[7:4]} : {4'b0, pix_q[3:0]};
    end else begin
      raw_idx = pix_q[7:0];
    end
    if (({1'b0, raw_idx} >= cfg_i.color_count) || ({1'b0, raw_idx} >= DepthLimit)) begin
      safe_idx = '0;
    end else begin
      safe_idx = raw_idx;
    end
  end

  always_comb begin
    op_o = '{kind: OP_LOOKUP, addr: safe_idx, data: pix_q, last: 1'b1};
    if (is_write) begin
      op_o = '{kind: OP_WRITE, addr: pidx_q, data: PIXEL_W'(pcol_q[RGB15_W-1:0]),
               last: 1'b1};
    end else begin
      case (cfg_i.pixel_mode)
        MODE_IDX4: op_o.last = phase_q;
        MODE_IDX8: op_o.last = 1'b1;
        MODE_RGB15: op_o.kind = OP_RGB15;
        MODE_RGB24: op_o.kind = OP_RGB24;
        default: op_o.kind = OP_RGB24;
      endcase
    end
  end

  always_comb begin
    hold_d  = hold_q;
    phase_d = phase_q;
    if (accept) begin
      hold_d  = 1'b1;
      phase_d = 1'b0;
    end else if (done) begin
      hold_d  = 1'b0;
    end else if (push && is_split) begin
      phase_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q  <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      hold_q  <= hold_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= in_i.func;
      pidx_q <= in_i.palette_index;
      pcol_q <= in_i.palette_color;
      pix_q  <= in_i.pixel_data;
    end
  end

endmodule

/* hdl/tpd_op_fifo.sv */
// ----------------------------------------------------------------------------
// Pixel palette decoder operation queue
// Short queue that decouples the front end from the palette back end.
// ----------------------------------------------------------------------------
module tpd_op_fifo (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  tpd_pkg::op_t wr_op_i,
  input  logic         wr_valid_i,
  output logic         wr_ready_o,
  output tpd_pkg::op_t rd_op_o,
  output logic         rd_valid_o,
  input  logic         rd_ready_i
);
  import tpd_pkg::*;

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  op_t             entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            wr_en;
  logic            rd_en;

  assign wr_ready_o = (count_q != CntW'(Depth));
  assign rd_valid_o = (count_q != '0);
  assign rd_op_o    = entry_q[rd_ptr_q];
  assign wr_en      = wr_valid_i & wr_ready_o;
  assign rd_en      = rd_valid_o & rd_ready_i;

  always_comb begin
    wr_ptr_d = wr_en ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = rd_en ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (wr_en && !rd_en) begin
      count_d = count_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_q[wr_ptr_q] <= wr_op_i;
    end
  end

endmodule

/* hdl/tpd_back.sv */
// ----------------------------------------------------------------------------
// Pixel palette decoder back end
// Palette memory, lookup stage and channel expansion into the output register.
// ----------------------------------------------------------------------------
module tpd_back #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  tpd_pkg::op_t op_i,
  input  logic         op_valid_i,
  output logic         op_ready_o,
  tpd_out_if.source    out_o
);
  import tpd_pkg::*;

  localparam int AddrW = $clog2(PALETTE_DEPTH);

  logic [RGB15_W-1:0] palette_q [PALETTE_DEPTH];
  logic [RGB15_W-1:0] rd_q;

  logic               a_valid_q, a_valid_d;
  op_kind_e           a_kind_q;
  logic               a_last_q;
  logic [PIXEL_W-1:0] a_data_q;

  logic               b_valid_q, b_valid_d;
  logic [CHAN_W-1:0]  b_red_q, b_green_q, b_blue_q;
  logic               b_last_q;

  logic               a_ready;
  logic               b_ready;
  logic               pop;
  logic [RGB15_W-1:0] color15;
  logic [CHAN_W-1:0]  red, green, blue;

  assign b_ready    = !b_valid_q | out_o.ready;
  assign a_ready    = !a_valid_q | b_ready;
  assign op_ready_o = a_ready;
  assign pop        = op_valid_i & a_ready;

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (op_i.kind == OP_WRITE) begin
        palette_q[op_i.addr[AddrW-1:0]] <= op_i.data[RGB15_W-1:0];
      end else if (op_i.kind == OP_LOOKUP) begin
        rd_q <= palette_q[op_i.addr[AddrW-1:0]];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      a_kind_q <= op_i.kind;
      a_last_q <= op_i.last;
      a_data_q <= op_i.data;
    end
  end

  always_comb begin
    color15 = (a_kind_q == OP_LOOKUP) ? rd_q : a_data_q[RGB15_W-1:0];
    case (a_kind_q)
      OP_RGB24: begin
        red   = a_data_q[23:16];
        green = a_data_q[15:8];
        blue  = a_data_q[7:0];
      end
      default: begin
        red   = chan_expand(color15[4:0]);
        green = chan_expand(color15[9:5]);
        blue  = chan_expand(color15[14:10]);
      end
    endcase
  end

  always_comb begin
    a_valid_d = a_valid_q;
    if (a_ready) begin
      a_valid_d = pop && (op_i.kind != OP_WRITE);
    end
    b_valid_d = b_valid_q;
    if (b_ready) begin
      b_valid_d = a_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      b_valid_q <= b_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_valid_q && b_ready) begin
      b_red_q   <= red;
      b_green_q <= green;
      b_blue_q  <= blue;
      b_last_q  <= a_last_q;
    end
  end

  assign out_o.valid        = b_valid_q;
  assign out_o.red          = b_red_q;
  assign out_o.green        = b_green_q;
  assign out_o.blue         = b_blue_q;
  assign out_o.last_of_item = b_last_q;

endmodule
